@@ rtl/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types, codes and helpers of the slot maximum tracker.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int SLOTS_DEF = 512;

  localparam int VALUE_W  = 64;
  localparam int SLOT_W   = 9;
  localparam int LEN_W    = 24;
  localparam int FUNC_W   = 3;
  localparam int COUNT_W  = 10;
  localparam int UPD_W    = 32;
  localparam int TICK_W   = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W   = VALUE_W + 1;  // persisted flag above best value

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 56;

  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PICK   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEACT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RETIRE_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd2;

  localparam logic [TICK_W-1:0]  INTERVAL_RST = 16'd20;
  localparam logic [LEN_W-1:0]   MAX_LEN_RST  = 24'd1048576;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 10'd1023;
  localparam logic [VALUE_W-1:0] ALL_ONES     = '1;

  typedef struct packed {
    logic [LEN_W-1:0]   input_length;
    logic [VALUE_W-1:0] observed_value;
    logic [SLOT_W-1:0]  slot_index;
    logic [FUNC_W-1:0]  func;
  } item_t;

  typedef struct packed {
    logic [UPD_W-1:0]   update_count;
    logic [COUNT_W-1:0] active_count;
    logic               retired;
    logic               improved;
    logic               schedule_now;
    logic               picked_valid;
    logic [SLOT_W-1:0]  picked_slot;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
    cnt_inc = (c < COUNT_LIMIT) ? c + 10'd1 : c;
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] c);
    cnt_dec = (c != '0) ? c - 10'd1 : c;
  endfunction

endpackage

@@ rtl/smt_slot_ram.sv @@
// ----------------------------------------------------------------------------
// smt_slot_ram
// Single write, single read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module smt_slot_ram #(
  parameter int DEPTH = smt_pkg::SLOTS_DEF,
  parameter int WIDTH = smt_pkg::WORD_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/smt_core.sv @@
// ----------------------------------------------------------------------------
// smt_core
// Sequencer: clearing pass, read-modify-write of one slot, round-robin scan,
// tick counter and the configuration registers.
// ----------------------------------------------------------------------------
module smt_core #(
  parameter int SLOTS = smt_pkg::SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smt_pkg::cfg_wr_t      cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  smt_pkg::item_t        item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output smt_pkg::result_t      res_o,
  output logic                  mem_we_o,
  output logic [$clog2(SLOTS)-1:0] mem_waddr_o,
  output logic [smt_pkg::WORD_W-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [$clog2(SLOTS)-1:0] mem_raddr_o,
  input  logic [smt_pkg::WORD_W-1:0] mem_rdata_i
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RMW   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [smt_pkg::FUNC_W-1:0]  func_q, func_d;
  logic [smt_pkg::VALUE_W-1:0] obs_q, obs_d;
  logic [smt_pkg::LEN_W-1:0]   len_q, len_d;

  logic [SW-1:0]                addr_q, addr_d;
  logic [SW-1:0]                scan_cnt_q, scan_cnt_d;
  logic [SW-1:0]                next_slot_q, next_slot_d;
  logic [smt_pkg::COUNT_W-1:0]  entry_cnt_q, entry_cnt_d;
  logic [smt_pkg::TICK_W-1:0]   tick_q, tick_d;
  logic [smt_pkg::UPD_W-1:0]    impr_cnt_q, impr_cnt_d;

  logic                         retire_en_q, retire_en_d;
  logic [smt_pkg::TICK_W-1:0]   interval_q, interval_d;
  logic [smt_pkg::LEN_W-1:0]    max_len_q, max_len_d;

  logic [smt_pkg::SLOT_W-1:0]   pslot_q, pslot_d;
  logic                         pvalid_q, pvalid_d;
  logic                         sched_q, sched_d;
  logic                         improved_q, improved_d;
  logic                         retired_q, retired_d;

  logic [smt_pkg::VALUE_W-1:0]  best;
  logic                         pers;
  logic                         len_ok;
  logic                         in_range;
  logic                         accept;
  logic                         match;
  logic [SW-1:0]                addr_nx;
  logic [smt_pkg::TICK_W-1:0]   tick_inc;
  logic [smt_pkg::COUNT_W-1:0]  cnt_mid;

  assign best     = mem_rdata_i[smt_pkg::VALUE_W-1:0];
  assign pers     = mem_rdata_i[smt_pkg::VALUE_W];
  assign len_ok   = (len_q != '0) && (len_q <= max_len_q);
  assign in_range = 32'(item_i.slot_index) < SLOTS;
  assign accept   = in_valid_i && in_ready_o;
  assign match    = (best != '0) && (!retire_en_q || best != smt_pkg::ALL_ONES);
  assign addr_nx  = (addr_q == LAST_SLOT) ? '0 : addr_q + SW'(1);
  assign tick_inc = tick_q + 16'd1;
  assign cnt_mid  = (best != '0) ? smt_pkg::cnt_dec(entry_cnt_q) : entry_cnt_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o.picked_slot  = pslot_q;
    res_o.picked_valid = pvalid_q;
    res_o.schedule_now = sched_q;
    res_o.improved     = improved_q;
    res_o.retired      = retired_q;
    res_o.active_count = entry_cnt_q;
    res_o.update_count = impr_cnt_q;
  end

  // configuration registers
  always_comb begin
    retire_en_d = retire_en_q;
    interval_d  = interval_q;
    max_len_d   = max_len_q;
    if (cfg_i.we) begin
      case (cfg_i.idx)
        smt_pkg::REG_RETIRE_EN: retire_en_d = cfg_i.data[0];
        smt_pkg::REG_INTERVAL:  interval_d  = cfg_i.data[smt_pkg::TICK_W-1:0];
        smt_pkg::REG_MAX_LEN:   max_len_d   = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    obs_d       = obs_q;
    len_d       = len_q;
    addr_d      = addr_q;
    scan_cnt_d  = scan_cnt_q;
    next_slot_d = next_slot_q;
    entry_cnt_d = entry_cnt_q;
    tick_d      = tick_q;
    impr_cnt_d  = impr_cnt_q;
    pslot_d     = pslot_q;
    pvalid_d    = pvalid_q;
    sched_d     = sched_q;
    improved_d  = improved_q;
    retired_d   = retired_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        addr_d   = addr_nx;
        if (addr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          func_d     = item_i.func;
          obs_d      = item_i.observed_value;
          len_d      = item_i.input_length;
          pslot_d    = '0;
          pvalid_d   = 1'b0;
          sched_d    = 1'b0;
          improved_d = 1'b0;
          retired_d  = 1'b0;
          state_d    = ST_DONE;
          case (item_i.func)
            smt_pkg::FUNC_UPDATE, smt_pkg::FUNC_LOAD, smt_pkg::FUNC_DEACT: begin
              if (in_range) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = SW'(item_i.slot_index);
                addr_d      = SW'(item_i.slot_index);
                state_d     = ST_RMW;
              end
            end
            smt_pkg::FUNC_PICK: begin
              if (entry_cnt_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = next_slot_q;
                addr_d      = next_slot_q;
                scan_cnt_d  = '0;
                state_d     = ST_SCAN;
              end
            end
            smt_pkg::FUNC_TICK: begin
              if (entry_cnt_q == '0) begin
                tick_d = '0;
              end else if (tick_inc >= interval_q) begin
                tick_d  = '0;
                sched_d = 1'b1;
              end else begin
                tick_d = tick_inc;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        state_d = ST_DONE;
        case (func_q)
          smt_pkg::FUNC_UPDATE: begin
            if (pers) begin
              if (obs_q > best) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = {1'b1, obs_q};
              end
            end else if (retire_en_q && best == smt_pkg::ALL_ONES) begin
              // retired slot stays as it is
            end else if (retire_en_q && obs_q == smt_pkg::ALL_ONES) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {1'b0, smt_pkg::ALL_ONES};
              entry_cnt_d = cnt_mid;
              impr_cnt_d  = impr_cnt_q + 32'd1;
              retired_d   = 1'b1;
            end else if (obs_q > best && len_ok) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {1'b0, obs_q};
              if (best == '0) begin
                entry_cnt_d = smt_pkg::cnt_inc(entry_cnt_q);
              end
              impr_cnt_d  = impr_cnt_q + 32'd1;
              improved_d  = 1'b1;
            end
          end
          smt_pkg::FUNC_LOAD: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {len_ok, 63'd0, len_ok};
            entry_cnt_d = len_ok ? smt_pkg::cnt_inc(cnt_mid) : cnt_mid;
          end
          smt_pkg::FUNC_DEACT: begin
            if (best != '0) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = '0;
              entry_cnt_d = cnt_mid;
            end
          end
          default: ;
        endcase
      end

      ST_SCAN: begin
        if (match) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {1'b0, best};
          next_slot_d = addr_nx;
          pslot_d     = smt_pkg::SLOT_W'(addr_q);
          pvalid_d    = 1'b1;
          state_d     = ST_DONE;
        end else if (scan_cnt_q == LAST_SLOT) begin
          state_d = ST_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = addr_nx;
          addr_d      = addr_nx;
          scan_cnt_d  = scan_cnt_q + SW'(1);
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      scan_cnt_q  <= '0;
      next_slot_q <= '0;
      entry_cnt_q <= '0;
      tick_q      <= '0;
      impr_cnt_q  <= '0;
      retire_en_q <= 1'b0;
      interval_q  <= smt_pkg::INTERVAL_RST;
      max_len_q   <= smt_pkg::MAX_LEN_RST;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      scan_cnt_q  <= scan_cnt_d;
      next_slot_q <= next_slot_d;
      entry_cnt_q <= entry_cnt_d;
      tick_q      <= tick_d;
      impr_cnt_q  <= impr_cnt_d;
      retire_en_q <= retire_en_d;
      interval_q  <= interval_d;
      max_len_q   <= max_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    obs_q      <= obs_d;
    len_q      <= len_d;
    pslot_q    <= pslot_d;
    pvalid_q   <= pvalid_d;
    sched_q    <= sched_d;
    improved_q <= improved_d;
    retired_q  <= retired_d;
  end

endmodule

@@ rtl/slot_max_tracker_round_robin.sv @@
// ----------------------------------------------------------------------------
// slot_max_tracker_round_robin
// Per-slot maximum tracker with persisted flags, active count and
// round-robin pick, state held in one slot RAM.
// ----------------------------------------------------------------------------
//   channel   direction  contents
//   s_axis    in         func, slot_index, observed_value, input_length
//   m_axis    out        one result transaction per input transaction
//   cfg       in         retire_enable, schedule_interval, max_input_length
//
// After reset the slot RAM is cleared, one entry a cycle, with s_axis_tready
// low until it is done. Update, load and deactivate of a slot in range pass
// through a RAM read, a modify and write, and the result; tick, unused codes,
// out-of-range slots and a pick with no active slot go straight to the result.
// Any other pick scans the RAM, one entry examined per cycle. The result sits
// in an output register, so a stalled m_axis holds only the next completion.
// ----------------------------------------------------------------------------
module slot_max_tracker_round_robin #(
  parameter int SLOTS = smt_pkg::SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [smt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smt_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // func[2:0], slot_index[11:3], observed_value[75:12], input_length[99:76]
  input  logic [smt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // picked_slot[8:0], picked_valid[9], schedule_now[10], improved[11],
  // retired[12], active_count[22:13], update_count[54:23]
  output logic [smt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int SW = $clog2(SLOTS);

  smt_pkg::cfg_wr_t  cfg;
  smt_pkg::item_t    item;
  smt_pkg::result_t  res;
  logic              res_valid;
  logic              res_ready;

  logic                        mem_we;
  logic [SW-1:0]               mem_waddr;
  logic [smt_pkg::WORD_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [SW-1:0]               mem_raddr;
  logic [smt_pkg::WORD_W-1:0]  mem_rdata;

  logic              out_valid_q, out_valid_d;
  smt_pkg::result_t  out_q, out_d;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;
  assign item     = s_axis_tdata[$bits(smt_pkg::item_t)-1:0];

  smt_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  smt_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (smt_pkg::WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slot maximum tracker. A directed table covers
// the edge cases, then eight randomised phases change the registers and the
// idle and stall rates on both streams. A shadow copy of the slot table gives
// the expected result of every accepted transaction that carries none of its
// own, and each result on the output stream is compared with it field by field.
// ----------------------------------------------------------------------------
module tb;
  import smt_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [LEN_W-1:0] LEN_ALL = '1;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    item_t                req;
    bit                   typed;
    result_t              exp;
  } plan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow state
  logic [VALUE_W-1:0] slot_best [SLOTS];
  bit                 slot_persisted [SLOTS];
  logic [COUNT_W-1:0] active_slots = '0;
  logic [SLOT_W-1:0]  rr_next = '0;
  logic [TICK_W-1:0]  tick_cnt = '0;
  logic [UPD_W-1:0]   update_total = '0;
  bit                 retire_on = 1'b0;
  logic [TICK_W-1:0]  sched_interval = INTERVAL_RST;
  logic [LEN_W-1:0]   len_limit = MAX_LEN_RST;

  result_t   awaited_results [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  result_t   got_res;
  result_t   exp_res;

  always #5 clk_i = ~clk_i;

  slot_max_tracker_round_robin #(.SLOTS(SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic void count_slot_in();
    if (active_slots < COUNT_LIMIT) active_slots = active_slots + 1'b1;
  endfunction

  function automatic void count_slot_out();
    if (active_slots != '0) active_slots = active_slots - 1'b1;
  endfunction

  function automatic result_t step_tracker(input item_t req);
    result_t            r;
    logic [VALUE_W-1:0] cur_best;
    bit                 len_good;
    bit                 found;
    int                 s;
    r = '0;
    found = 1'b0;
    cur_best = slot_best[req.slot_index];
    len_good = (req.input_length != '0) && (req.input_length <= len_limit);
    case (req.func)
      FUNC_UPDATE: begin
        if (slot_persisted[req.slot_index]) begin
          if (req.observed_value > cur_best) slot_best[req.slot_index] = req.observed_value;
        end else if (retire_on && cur_best == ALL_ONES) begin
          // retired slot stays as it is
        end else if (retire_on && req.observed_value == ALL_ONES) begin
          if (cur_best != '0) count_slot_out();
          slot_best[req.slot_index] = ALL_ONES;
          update_total = update_total + 1'b1;
          r.retired = 1'b1;
        end else if (req.observed_value > cur_best && len_good) begin
          slot_persisted[req.slot_index] = 1'b0;
          if (cur_best == '0) count_slot_in();
          slot_best[req.slot_index] = req.observed_value;
          update_total = update_total + 1'b1;
          r.improved = 1'b1;
        end
      end
      FUNC_PICK: begin
        if (active_slots != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            s = (int'(rr_next) + i) % SLOTS;
            if (!found && slot_best[s] != '0 && !(retire_on && slot_best[s] == ALL_ONES)) begin
              found = 1'b1;
              rr_next = SLOT_W'((s + 1) % SLOTS);
              slot_persisted[s] = 1'b0;
              r.picked_slot = SLOT_W'(s);
              r.picked_valid = 1'b1;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (active_slots == '0) begin
          tick_cnt = '0;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= sched_interval) begin
            tick_cnt = '0;
            r.schedule_now = 1'b1;
          end
        end
      end
      FUNC_LOAD: begin
        if (cur_best != '0) count_slot_out();
        slot_best[req.slot_index] = '0;
        slot_persisted[req.slot_index] = 1'b0;
        if (len_good) begin
          slot_best[req.slot_index] = 1;
          slot_persisted[req.slot_index] = 1'b1;
          count_slot_in();
        end
      end
      FUNC_DEACT: begin
        if (cur_best != '0) begin
          slot_best[req.slot_index] = '0;
          slot_persisted[req.slot_index] = 1'b0;
          count_slot_out();
        end
      end
      default: ;
    endcase
    r.active_count = active_slots;
    r.update_count = update_total;
    return r;
  endfunction

  function automatic item_t random_request();
    item_t r;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 45) r.func = FUNC_UPDATE;
    else if (pick < 60) r.func = FUNC_PICK;
    else if (pick < 72) r.func = FUNC_TICK;
    else if (pick < 82) r.func = FUNC_LOAD;
    else if (pick < 92) r.func = FUNC_DEACT;
    else r.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    // mostly a small hot set so slots get revisited
    pick = $urandom_range(15);
    if ($urandom_range(99) < 70) r.slot_index = SLOT_W'((pick < 8) ? pick : 496 + pick);
    else r.slot_index = SLOT_W'($urandom_range(SLOTS - 1));
    pick = $urandom_range(99);
    if (pick < 15) r.observed_value = ALL_ONES;
    else if (pick < 40) r.observed_value = VALUE_W'($urandom_range(1000));
    else if (pick < 60) r.observed_value = slot_best[r.slot_index] + $urandom_range(2);
    else r.observed_value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 15) r.input_length = '0;
    else if (pick < 30) r.input_length = 1;
    else if (pick < 45) r.input_length = len_limit;
    else if (pick < 55) r.input_length = len_limit + 1'b1;
    else if (pick < 65) r.input_length = LEN_ALL;
    else r.input_length = LEN_W'($urandom);
    return r;
  endfunction

  function automatic result_t res(input logic [SLOT_W-1:0] pick, input bit pv, input bit sched,
                                  input bit impr, input bit ret, input logic [COUNT_W-1:0] act,
                                  input logic [UPD_W-1:0] upd);
    result_t r;
    r.picked_slot = pick;
    r.picked_valid = pv;
    r.schedule_now = sched;
    r.improved = impr;
    r.retired = ret;
    r.active_count = act;
    r.update_count = upd;
    return r;
  endfunction

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endtask

  task automatic plan_req(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] slot,
                          input logic [VALUE_W-1:0] val, input logic [LEN_W-1:0] len,
                          input bit typed, input result_t exp);
    plan_row_t row;
    row = '0;
    row.req.func = fn;
    row.req.slot_index = slot;
    row.req.observed_value = val;
    row.req.input_length = len;
    row.typed = typed;
    row.exp = exp;
    plan.push_back(row);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RETIRE_EN: retire_on = val[0];
      REG_INTERVAL:  sched_interval = val[TICK_W-1:0];
      REG_MAX_LEN:   len_limit = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic quiesce;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic push_request(input item_t req, input bit typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, req};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = step_tracker(req);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  // result side: check accepted transactions, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got_res);
        mismatches++;
      end else begin
        exp_res = awaited_results.pop_front();
        check_field("picked_slot", exp_res.picked_slot, got_res.picked_slot);
        check_field("picked_valid", exp_res.picked_valid, got_res.picked_valid);
        check_field("schedule_now", exp_res.schedule_now, got_res.schedule_now);
        check_field("improved", exp_res.improved, got_res.improved);
        check_field("retired", exp_res.retired, got_res.retired);
        check_field("active_count", exp_res.active_count, got_res.active_count);
        check_field("update_count", exp_res.update_count, got_res.update_count);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned wait_cycles;
    for (int i = 0; i < SLOTS; i++) begin
      slot_best[i] = '0;
      slot_persisted[i] = 1'b0;
    end

    // directed table, reset settings first
    plan_req(FUNC_PICK, 0, 0, 0, 1, res(0, 0, 0, 0, 0, 0, 0));
    plan_req(FUNC_TICK, 0, 0, 0, 1, res(0, 0, 0, 0, 0, 0, 0));
    plan_req(FUNC_UPDATE, 0, 1, 0, 1, res(0, 0, 0, 0, 0, 0, 0));
    plan_req(FUNC_UPDATE, 511, ALL_ONES, MAX_LEN_RST, 1, res(0, 0, 0, 1, 0, 1, 1));
    plan_req(FUNC_UPDATE, 511, 5, 1, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_req(FUNC_UPDATE, 0, 1, MAX_LEN_RST + 1'b1, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_req(FUNC_LOAD, 5, 0, LEN_ALL, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_req(FUNC_LOAD, 5, 0, 1, 1, res(0, 0, 0, 0, 0, 2, 1));
    plan_req(FUNC_UPDATE, 5, 100, 0, 1, res(0, 0, 0, 0, 0, 2, 1));
    plan_req(FUNC_PICK, 0, 0, 0, 1, res(5, 1, 0, 0, 0, 2, 1));
    plan_req(FUNC_PICK, 0, 0, 0, 1, res(511, 1, 0, 0, 0, 2, 1));
    plan_req(FUNC_DEACT, 511, 0, 0, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_req(FUNC_DEACT, 511, 0, 0, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_req(FUNC_SPARE_LO, 5, 3, 1, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_req(FUNC_SPARE_HI, 511, ALL_ONES, LEN_ALL, 1, res(0, 0, 0, 0, 0, 1, 1));
    plan_cfg(REG_RETIRE_EN, 1);
    plan_req(FUNC_UPDATE, 5, ALL_ONES, 0, 1, res(0, 0, 0, 0, 1, 0, 2));
    plan_req(FUNC_UPDATE, 5, 7, 1, 1, res(0, 0, 0, 0, 0, 0, 2));
    plan_req(FUNC_PICK, 0, 0, 0, 1, res(0, 0, 0, 0, 0, 0, 2));
    plan_cfg(REG_INTERVAL, 0);
    plan_req(FUNC_UPDATE, 10, ALL_ONES - 1'b1, 1, 1, res(0, 0, 0, 1, 0, 1, 3));
    plan_req(FUNC_TICK, 0, 0, 0, 1, res(0, 0, 1, 0, 0, 1, 3));
    plan_req(FUNC_PICK, 0, 0, 0, 1, res(10, 1, 0, 0, 0, 1, 3));
    plan_cfg(REG_INTERVAL, 1);
    plan_cfg(REG_MAX_LEN, LEN_ALL);
    plan_cfg(REG_RETIRE_EN, 0);
    plan_req(FUNC_LOAD, 10, 0, LEN_ALL, 1, res(0, 0, 0, 0, 0, 1, 3));
    plan_req(FUNC_UPDATE, 10, ALL_ONES, 0, 0, '0);
    plan_req(FUNC_PICK, 0, 0, 0, 0, '0);
    plan_req(FUNC_TICK, 0, 0, 0, 0, '0);
    plan_cfg(REG_MAX_LEN, 1);
    plan_req(FUNC_UPDATE, 20, 2, 1, 0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        quiesce();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
        cfg_we_i <= 1'b0;
      end else begin
        push_request(plan[k].req, plan[k].typed, plan[k].exp);
      end
    end

    // random phases, each starting from an idle block
    for (int p = 0; p < 8; p++) begin
      quiesce();
      case (p)
        0: begin
          write_reg(REG_RETIRE_EN, 0); write_reg(REG_INTERVAL, 20); write_reg(REG_MAX_LEN, MAX_LEN_RST);
        end
        1: begin
          write_reg(REG_RETIRE_EN, 1); write_reg(REG_INTERVAL, 3); write_reg(REG_MAX_LEN, 1000);
        end
        2: begin
          write_reg(REG_RETIRE_EN, 0); write_reg(REG_INTERVAL, 1); write_reg(REG_MAX_LEN, 1);
        end
        3: begin
          write_reg(REG_RETIRE_EN, 1); write_reg(REG_INTERVAL, 65535); write_reg(REG_MAX_LEN, LEN_ALL);
        end
        4: begin
          write_reg(REG_RETIRE_EN, 1); write_reg(REG_INTERVAL, 2); write_reg(REG_MAX_LEN, LEN_ALL);
        end
        5: begin
          write_reg(REG_RETIRE_EN, 0); write_reg(REG_INTERVAL, 0); write_reg(REG_MAX_LEN, 500000);
        end
        6: begin
          write_reg(REG_RETIRE_EN, 1); write_reg(REG_INTERVAL, 5); write_reg(REG_MAX_LEN, 1);
        end
        default: begin
          write_reg(REG_RETIRE_EN, 0); write_reg(REG_INTERVAL, 4); write_reg(REG_MAX_LEN, LEN_ALL);
        end
      endcase
      cfg_we_i <= 1'b0;
      src_idle_pct = (p % 4 == 1) ? 49 : (p % 4 == 3) ? 36 : 0;
      sink_stall_pct = (p % 4 == 2) ? 49 : (p % 4 == 3) ? 36 : 0;
      for (int n = 0; n < 81; n++) push_request(random_request(), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (awaited_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0", $time,
               awaited_results.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
